FILE: hw/rtl/clp_pkg.sv
// Shared types, codes and line tables for the charlieplexed LED scanner.
package clp_pkg;

	// Input transaction kinds
	typedef enum logic [1:0] {
		KIND_TICK          = 2'd0,
		KIND_SET_LED       = 2'd1,
		KIND_SET_INTENSITY = 2'd2
	} kind_t;

	// Configuration register indexes
	localparam logic CFG_BLINK_PERIOD = 1'b0;
	localparam logic CFG_SCAN_PERIOD  = 1'b1;

	// Configuration reset values
	localparam logic [15:0] BLINK_PERIOD_RST = 16'd500;
	localparam logic [15:0] SCAN_PERIOD_RST  = 16'd2;
	localparam logic [15:0] ELAPSED_MAX      = 16'hFFFF;

	// Timer events for one processed transaction
	typedef struct packed {
		logic blink_flip;
		logic scan_fire;
	} scan_evt_t;

	// Anode line of each LED slot
	function automatic logic [1:0] anode_of(input logic [3:0] slot);
		logic [1:0] a;
		case (slot)
			4'd0:    a = 2'd0;
			4'd1:    a = 2'd1;
			4'd2:    a = 2'd1;
			4'd3:    a = 2'd2;
			4'd4:    a = 2'd1;
			4'd5:    a = 2'd3;
			4'd6:    a = 2'd2;
			4'd7:    a = 2'd3;
			4'd8:    a = 2'd0;
			4'd9:    a = 2'd0;
			4'd10:   a = 2'd2;
			4'd11:   a = 2'd3;
			default: a = 2'd0;
		endcase
		return a;
	endfunction

	// Cathode line of each LED slot
	function automatic logic [1:0] cathode_of(input logic [3:0] slot);
		logic [1:0] c;
		case (slot)
			4'd0:    c = 2'd1;
			4'd1:    c = 2'd0;
			4'd2:    c = 2'd2;
			4'd3:    c = 2'd1;
			4'd4:    c = 2'd3;
			4'd5:    c = 2'd1;
			4'd6:    c = 2'd3;
			4'd7:    c = 2'd2;
			4'd8:    c = 2'd3;
			4'd9:    c = 2'd2;
			4'd10:   c = 2'd0;
			4'd11:   c = 2'd0;
			default: c = 2'd0;
		endcase
		return c;
	endfunction

endpackage

FILE: hw/rtl/charlieplex_led_scanner.sv
// Top level of the charlieplexed LED scanner: input stage, result register.
//
//  channel  | handshake            | payload
//  ---------+----------------------+-------------------------------------------
//  input    | in_valid / in_ready  | kind, led, lit, intensity, blink
//  result   | out_valid / out_ready| scanned_led, active, anode_line,
//           |                      | cathode_line, duty
//  config   | cfg_we               | cfg_index, cfg_data
//
// One transaction per cycle unless the result stalls: an item is registered, then
// processed through the timer and LED bank into the result register.
// A tick that completes a scan period yields one result; other items yield none.
// Asynchronous reset loads all control, timer and LED state; payload registers
// carry no reset since their valid bits guard them. No clearing pass is needed.
// A stalled result holds the input stage; the input register and the result
// register let a new item enter while the result waits to be taken.
module charlieplex_led_scanner #(
	parameter int         NUM_LEDS          = 9,
	parameter logic [7:0] DEFAULT_INTENSITY = 8'd128
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [1:0]  kind,
	input  logic [3:0]  led,
	input  logic        lit,
	input  logic [7:0]  intensity,
	input  logic        blink,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [3:0]  scanned_led,
	output logic        active,
	output logic [1:0]  anode_line,
	output logic [1:0]  cathode_line,
	output logic [7:0]  duty,
	input  logic        cfg_we,
	input  logic        cfg_index,
	input  logic [15:0] cfg_data
);

	localparam int POS_W = (NUM_LEDS > 1) ? $clog2(NUM_LEDS) : 1;

	logic               valid_s1;
	logic [1:0]         kind_s1;
	logic [3:0]         led_s1;
	logic               lit_s1;
	logic [7:0]         intensity_s1;
	logic               blink_s1;
	logic               adv_s1;
	logic               tick;
	logic               set_led;
	logic               set_inten;
	logic               led_ok;
	clp_pkg::scan_evt_t evt;
	logic [POS_W-1:0]   pos;
	logic               res_active;
	logic [1:0]         res_anode;
	logic [1:0]         res_cathode;
	logic [7:0]         res_duty;
	logic               out_valid_s2;
	logic [3:0]         scanned_led_s2;
	logic               active_s2;
	logic [1:0]         anode_line_s2;
	logic [1:0]         cathode_line_s2;
	logic [7:0]         duty_s2;

	// Stage 1 moves on when the result register is free or being emptied
	assign adv_s1   = valid_s1 && (!out_valid_s2 || out_ready);
	assign in_ready = !valid_s1 || adv_s1;

	// Decode of the staged transaction
	assign led_ok    = (led_s1 < 4'(NUM_LEDS));
	assign tick      = adv_s1 && (kind_s1 == clp_pkg::KIND_TICK);
	assign set_led   = adv_s1 && led_ok && (kind_s1 == clp_pkg::KIND_SET_LED);
	assign set_inten = adv_s1 && led_ok && (kind_s1 == clp_pkg::KIND_SET_INTENSITY);

	// Input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_valid && in_ready) begin
			valid_s1 <= 1'b1;
		end else if (adv_s1) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			kind_s1      <= kind;
			led_s1       <= led;
			lit_s1       <= lit;
			intensity_s1 <= intensity;
			blink_s1     <= blink;
		end
	end

	clp_scan_timer #(
		.NUM_LEDS (NUM_LEDS),
		.POS_W    (POS_W)
	) u_timer (
		.clk       (clk),
		.arst_n    (arst_n),
		.tick      (tick),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.evt       (evt),
		.pos       (pos)
	);

	clp_led_bank #(
		.NUM_LEDS          (NUM_LEDS),
		.POS_W             (POS_W),
		.DEFAULT_INTENSITY (DEFAULT_INTENSITY)
	) u_bank (
		.clk          (clk),
		.arst_n       (arst_n),
		.set_led      (set_led),
		.set_inten    (set_inten),
		.led          (led_s1),
		.lit          (lit_s1),
		.intensity    (intensity_s1),
		.blink        (blink_s1),
		.evt          (evt),
		.pos          (pos),
		.active       (res_active),
		.anode_line   (res_anode),
		.cathode_line (res_cathode),
		.duty         (res_duty)
	);

	// Result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_s2 <= 1'b0;
		end else if (adv_s1) begin
			out_valid_s2 <= evt.scan_fire;
		end else if (out_ready) begin
			out_valid_s2 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (evt.scan_fire) begin
			scanned_led_s2  <= 4'(pos);
			active_s2       <= res_active;
			anode_line_s2   <= res_anode;
			cathode_line_s2 <= res_cathode;
			duty_s2         <= res_duty;
		end
	end

	assign out_valid    = out_valid_s2;
	assign scanned_led  = scanned_led_s2;
	assign active       = active_s2;
	assign anode_line   = anode_line_s2;
	assign cathode_line = cathode_line_s2;
	assign duty         = duty_s2;

`ifndef NO_ASSERTIONS
	// Scan position never leaves the LED range
	a_pos_range: assert property (@(posedge clk) disable iff (!arst_n)
		32'(pos) < NUM_LEDS)
		else $error("scan position out of range");

	// An idle LED drives no lines and no duty
	a_inactive_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && !active) |->
		(anode_line == 2'd0 && cathode_line == 2'd0 && duty == 8'd0))
		else $error("inactive result carries line or duty data");

	// Input is held off only by a stalled result
	a_ready_stall: assert property (@(posedge clk) disable iff (!arst_n)
		!in_ready |-> (valid_s1 && out_valid && !out_ready))
		else $error("input stalled without a waiting result");

	// A result is only produced by a processed tick
	a_result_src: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && !$past(out_valid && !out_ready)) |->
		$past(adv_s1 && kind_s1 == clp_pkg::KIND_TICK))
		else $error("result without a tick");
`endif

endmodule

FILE: hw/rtl/clp_scan_timer.sv
// Blink and scan period counters, period registers and scan position.
module clp_scan_timer #(
	parameter int NUM_LEDS = 9,
	parameter int POS_W    = 4
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 tick,
	input  logic                 cfg_we,
	input  logic                 cfg_index,
	input  logic [15:0]          cfg_data,
	output clp_pkg::scan_evt_t   evt,
	output logic [POS_W-1:0]     pos
);

	logic [15:0]      blink_period_q;
	logic [15:0]      scan_period_q;
	logic [15:0]      blink_elapsed_q;
	logic [15:0]      scan_elapsed_q;
	logic [POS_W-1:0] pos_q;
	logic [15:0]      blink_inc;
	logic [15:0]      scan_inc;

	// Saturating increments; a zero period fires like a period of one
	assign blink_inc = (blink_elapsed_q == clp_pkg::ELAPSED_MAX) ?
	                   blink_elapsed_q : blink_elapsed_q + 16'd1;
	assign scan_inc  = (scan_elapsed_q == clp_pkg::ELAPSED_MAX) ?
	                   scan_elapsed_q : scan_elapsed_q + 16'd1;

	assign evt.blink_flip = tick && (blink_inc >= blink_period_q);
	assign evt.scan_fire  = tick && (scan_inc >= scan_period_q);
	assign pos            = pos_q;

	// Configuration writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			blink_period_q <= clp_pkg::BLINK_PERIOD_RST;
			scan_period_q  <= clp_pkg::SCAN_PERIOD_RST;
		end else if (cfg_we) begin
			case (cfg_index)
				clp_pkg::CFG_BLINK_PERIOD: blink_period_q <= cfg_data;
				clp_pkg::CFG_SCAN_PERIOD:  scan_period_q  <= cfg_data;
				default: ;
			endcase
		end
	end

	// Elapsed counters and scan position advance on ticks
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			blink_elapsed_q <= '0;
			scan_elapsed_q  <= '0;
			pos_q           <= '0;
		end else if (tick) begin
			blink_elapsed_q <= evt.blink_flip ? 16'd0 : blink_inc;
			scan_elapsed_q  <= evt.scan_fire ? 16'd0 : scan_inc;
			if (evt.scan_fire) begin
				pos_q <= (pos_q == POS_W'(NUM_LEDS - 1)) ? '0 : pos_q + POS_W'(1);
			end
		end
	end

endmodule

FILE: hw/rtl/clp_led_bank.sv
// Per-LED flag and intensity registers, plus lookup of the scanned LED.
module clp_led_bank #(
	parameter int         NUM_LEDS          = 9,
	parameter int         POS_W             = 4,
	parameter logic [7:0] DEFAULT_INTENSITY = 8'd128
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               set_led,
	input  logic               set_inten,
	input  logic [3:0]         led,
	input  logic               lit,
	input  logic [7:0]         intensity,
	input  logic               blink,
	input  clp_pkg::scan_evt_t evt,
	input  logic [POS_W-1:0]   pos,
	output logic               active,
	output logic [1:0]         anode_line,
	output logic [1:0]         cathode_line,
	output logic [7:0]         duty
);

	logic       lit_q   [NUM_LEDS];
	logic       blink_q [NUM_LEDS];
	logic       phase_q [NUM_LEDS];
	logic [7:0] inten_q [NUM_LEDS];
	logic       phase_now;
	logic [3:0] slot;

	// Updates, blink phase flips
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < NUM_LEDS; i++) begin
				lit_q[i]   <= 1'b0;
				blink_q[i] <= 1'b0;
				phase_q[i] <= 1'b1;
				inten_q[i] <= DEFAULT_INTENSITY;
			end
		end else begin
			for (int i = 0; i < NUM_LEDS; i++) begin
				if ((set_led || set_inten) && led == 4'(i)) begin
					inten_q[i] <= intensity;
				end
				if (set_led && led == 4'(i)) begin
					lit_q[i]   <= lit;
					blink_q[i] <= blink;
				end
				if (evt.blink_flip && blink_q[i]) begin
					phase_q[i] <= ~phase_q[i];
				end
			end
		end
	end

	// Result for the scanned LED; phase reflects a flip on the same tick
	always_comb begin
		slot         = 4'(pos);
		phase_now    = phase_q[pos] ^ (evt.blink_flip && blink_q[pos]);
		active       = lit_q[pos] && !(blink_q[pos] && !phase_now);
		anode_line   = active ? clp_pkg::anode_of(slot) : 2'd0;
		cathode_line = active ? clp_pkg::cathode_of(slot) : 2'd0;
		duty         = active ? inten_q[pos] : 8'd0;
	end

endmodule
